[src/rfd_pkg.sv]
package rfd_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned SlotW = 3;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW  = 2;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_FRAME_HDR     = 3'd0,
    REG_ACTIVE_MASK   = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_OPEN_CODE     = 3'd3,
    REG_CLOSE_CODE    = 3'd4
  } reg_idx_e;

  // Result kinds on the radio link
  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  localparam logic [ByteW-1:0] ChannelCountRst = 8'd38;

  typedef struct packed {
    logic [ByteW-1:0] frame_hdr;
    logic [ByteW-1:0] active_mask;
    logic [ByteW-1:0] channel_count;
    logic [ByteW-1:0] open_code;
    logic [ByteW-1:0] close_code;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
  } result_t;

  // All results caused by one item, packed from entry 0 upward
  typedef struct packed {
    logic [CntW-1:0]                count;
    result_t [MaxResults-1:0]       ent;
  } bundle_t;

endpackage

[src/rfd_cfg_regs.sv]
module rfd_cfg_regs
  import rfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_index_i,
  input  logic [ByteW-1:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_FRAME_HDR:     cfg_d.frame_hdr     = wr_data_i;
        REG_ACTIVE_MASK:   cfg_d.active_mask   = wr_data_i;
        REG_CHANNEL_COUNT: cfg_d.channel_count = wr_data_i;
        REG_OPEN_CODE:     cfg_d.open_code     = wr_data_i;
        REG_CLOSE_CODE:    cfg_d.close_code    = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_hdr     <= '0;
      cfg_q.active_mask   <= '0;
      cfg_q.channel_count <= ChannelCountRst;
      cfg_q.open_code     <= '0;
      cfg_q.close_code    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/rfd_frame_ctrl.sv]
module rfd_frame_ctrl
  import rfd_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             accept_i,
  input  logic [ByteW-1:0] in_byte_i,
  output bundle_t          bundle_o
);

  logic             in_frame_q, in_frame_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [ByteW-1:0] count_q, count_d;

  logic             active, first, final_byte, last_slot;
  logic [ByteW-1:0] count_inc;
  result_t          r_open, r_data, r_close;

  assign count_inc  = count_q + 8'd1;
  assign active     = cfg_i.active_mask[slot_q];
  assign first      = (count_q == '0);
  assign final_byte = (count_inc == cfg_i.channel_count);
  assign last_slot  = (slot_q == SlotW'(SLOT_COUNT - 1));

  assign r_open  = '{data: cfg_i.open_code  | {{(ByteW-SlotW){1'b0}}, slot_q}, kind: KIND_OPEN};
  assign r_data  = '{data: in_byte_i, kind: KIND_DATA};
  assign r_close = '{data: cfg_i.close_code | {{(ByteW-SlotW){1'b0}}, slot_q}, kind: KIND_CLOSE};

  // Results of this item, packed in link order
  always_comb begin
    bundle_o.count  = '0;
    bundle_o.ent[0] = first ? r_open : r_data;
    bundle_o.ent[1] = first ? r_data : r_close;
    bundle_o.ent[2] = r_close;
    if (accept_i && in_frame_q && active) begin
      bundle_o.count = CntW'(1) + CntW'(first) + CntW'(final_byte);
    end
  end

  // Frame walk: header detect, slot and byte counting
  always_comb begin
    in_frame_d = in_frame_q;
    slot_d     = slot_q;
    count_d    = count_q;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (in_byte_i == cfg_i.frame_hdr) begin
          in_frame_d = 1'b1;
          slot_d     = '0;
          count_d    = '0;
        end
      end else if (final_byte) begin
        count_d = '0;
        if (last_slot) begin
          in_frame_d = 1'b0;
          slot_d     = '0;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      slot_q     <= '0;
      count_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      slot_q     <= slot_d;
      count_q    <= count_d;
    end
  end

endmodule

[src/rfd_out_buf.sv]
module rfd_out_buf
  import rfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bundle_t          bundle_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic [1:0]       out_kind_o,
  output logic             out_last_o
);

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          rd_q, rd_d;
  result_t [MaxResults-1:0] ent_q;
  logic                     pop, pop_last, load;
  result_t                  cur;

  assign cur         = ent_q[rd_q];
  assign out_valid_o = (cnt_q != '0);
  assign out_last_o  = (rd_q == cnt_q - CntW'(1));
  assign out_byte_o  = cur.data;
  assign out_kind_o  = cur.kind;

  assign pop      = out_valid_o && !out_stall_i;
  assign pop_last = pop && out_last_o;
  assign free_o   = !out_valid_o || pop_last;
  assign load     = (bundle_i.count != '0);

  // Drain one result per cycle unless the radio side stalls; a new item may load as the last one leaves
  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load) begin
      cnt_d = bundle_i.count;
      rd_d  = '0;
    end else if (pop_last) begin
      cnt_d = '0;
      rd_d  = '0;
    end else if (pop) begin
      rd_d = rd_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= bundle_i.ent;
    end
  end

endmodule

[src/receiver_frame_distributor.sv]
// Receiver frame distributor: takes one host byte per item, waits for the
// frame header, then walks SLOT_COUNT receiver slots of channel_count bytes
// each; active slots get an opening byte, their data bytes and a closing
// byte, inactive slots are swallowed. An item is decoded in the cycle it is
// accepted and its zero to three results land in a three-entry output
// buffer that drains one result per cycle unless the radio side stalls.
// An item with two or more results stalls the input until the cycle its
// last result leaves, and a new item is accepted in that same cycle (the
// single output port sets this); items with zero or one result are taken
// every cycle while the radio side does not stall. Register writes apply
// from the next item; a channel_count of 0 means 256 bytes.
module receiver_frame_distributor
  import rfd_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [ByteW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic [1:0]       out_kind_o,
  output logic             out_last_o
);

  cfg_t    cfg;
  bundle_t bundle;
  logic    buf_free;
  logic    in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !buf_free;
  assign in_accept   = in_valid_i && buf_free;

  // Configuration registers
  rfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Frame tracking and result build
  rfd_frame_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (in_accept),
    .in_byte_i (in_byte_i),
    .bundle_o  (bundle)
  );

  // Output buffer
  rfd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bundle_i    (bundle),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .out_last_o  (out_last_o)
  );

`ifndef SYNTHESIS
  // Input must wait while buffered results other than the last remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> in_stall_o)
    else $error("input accepted with results still pending");

  // Taking the last result frees the input side in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled after last result left");

  // A closing byte always ends the results of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_CLOSE |-> out_last_o)
    else $error("closing byte not marked last");

  // An opening byte is always followed by its data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_OPEN |-> !out_last_o)
    else $error("opening byte marked last");
`endif

endmodule

[dv/tb_receiver_frame_distributor.sv]
`timescale 1ns / 100ps

module tb_receiver_frame_distributor;
  import rfd_pkg::*;

  localparam int unsigned SlotCount = 8;
  localparam int CycLimit = 200000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles = 150;

  // One byte expected on the radio link
  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
    logic             last;
  } radio_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IdxW-1:0]  cfg_index_i = '0;
  logic [ByteW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] in_byte_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ByteW-1:0] out_byte_o;
  logic [1:0]       out_kind_o;
  logic             out_last_o;

  // Host bytes waiting to be sent, radio bytes waiting to arrive
  logic [ByteW-1:0] host_q[$];
  radio_t           radio_exp_q[$];

  // Shadow of the registers and the frame walk
  cfg_t             reg_copy;
  logic             frm_open = 1'b0;
  logic [SlotW-1:0] slot_m = '0;
  logic [ByteW-1:0] cnt_m = '0;

  logic   in_taken = 1'b0;
  logic   out_taken = 1'b0;
  logic   calm = 1'b0;
  logic   hold_req = 1'b0;
  logic   hold_done = 1'b0;
  int     hold_cnt = 0;
  int     send_wait = 0;
  int     rx_wait = 0;
  int     err_cnt = 0;
  int     cyc_cnt = 0;
  radio_t want_r;

  receiver_frame_distributor #(
    .SLOT_COUNT(SlotCount)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_kind_o (out_kind_o),
    .out_last_o (out_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Walk one host byte through the frame and queue the radio bytes it yields
  task automatic predict_radio(input logic [ByteW-1:0] b);
    logic             hit;
    logic             fin;
    logic [ByteW-1:0] nxt;
    radio_t           r;
    if (!frm_open) begin
      if (b == reg_copy.frame_hdr) begin
        frm_open = 1'b1;
        slot_m = '0;
        cnt_m = '0;
      end
    end else begin
      hit = reg_copy.active_mask[slot_m];
      nxt = cnt_m + 8'd1;
      fin = (nxt == reg_copy.channel_count);
      if (hit) begin
        if (cnt_m == '0) begin
          r.data = reg_copy.open_code | ByteW'(slot_m);
          r.kind = KIND_OPEN;
          r.last = 1'b0;
          radio_exp_q.push_back(r);
        end
        r.data = b;
        r.kind = KIND_DATA;
        r.last = !fin;
        radio_exp_q.push_back(r);
        if (fin) begin
          r.data = reg_copy.close_code | ByteW'(slot_m);
          r.kind = KIND_CLOSE;
          r.last = 1'b1;
          radio_exp_q.push_back(r);
        end
      end
      if (fin) begin
        cnt_m = '0;
        if (int'(slot_m) + 1 >= int'(SlotCount)) begin
          frm_open = 1'b0;
          slot_m = '0;
        end else begin
          slot_m = slot_m + SlotW'(1);
        end
      end else begin
        cnt_m = nxt;
      end
    end
  endtask

  // Host side: one item per handshake, random gap after each item, none while calm
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (send_wait > 0) begin
        in_valid_i <= 1'b0;
        send_wait--;
      end else if (host_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_byte_i <= host_q.pop_front();
        send_wait = calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Radio side: random stall after each byte taken, none while calm; one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt = HoldCycles;
      hold_done = 1'b1;
    end
    if (out_taken) rx_wait = calm ? 0 : $urandom_range(0, 3);
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Track register writes and host bytes, check radio bytes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_FRAME_HDR:     reg_copy.frame_hdr = cfg_data_i;
          REG_ACTIVE_MASK:   reg_copy.active_mask = cfg_data_i;
          REG_CHANNEL_COUNT: reg_copy.channel_count = cfg_data_i;
          REG_OPEN_CODE:     reg_copy.open_code = cfg_data_i;
          REG_CLOSE_CODE:    reg_copy.close_code = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_radio(in_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (radio_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected radio byte: expected none, got byte %0h kind %0d last %0b",
                   $time, out_byte_o, out_kind_o, out_last_o);
        end else begin
          want_r = radio_exp_q.pop_front();
          if (out_byte_o != want_r.data) begin
            err_cnt++;
            $display("%0t: byte mismatch: expected %0h, got %0h", $time, want_r.data,
                     out_byte_o);
          end
          if (out_kind_o != want_r.kind) begin
            err_cnt++;
            $display("%0t: kind mismatch: expected %0d, got %0d", $time, want_r.kind,
                     out_kind_o);
          end
          if (out_last_o != want_r.last) begin
            err_cnt++;
            $display("%0t: last mismatch: expected %0b, got %0b", $time, want_r.last,
                     out_last_o);
          end
        end
      end
    end
    in_taken <= in_valid_i && !in_stall_o;
    out_taken <= out_valid_o && !out_stall_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt == CycLimit) begin
      $display("receiver_frame_distributor verification failed");
      $finish;
    end
  end

  // Register write; returns at a rising edge
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] mask,
                           input logic [ByteW-1:0] cnt, input logic [ByteW-1:0] opn,
                           input logic [ByteW-1:0] cls);
    write_reg(REG_FRAME_HDR, hdr);
    write_reg(REG_ACTIVE_MASK, mask);
    write_reg(REG_CHANNEL_COUNT, cnt);
    write_reg(REG_OPEN_CODE, opn);
    write_reg(REG_CLOSE_CODE, cls);
  endtask

  task automatic push_rand(input int n);
    repeat (n) host_q.push_back(8'($urandom));
  endtask

  // Wait until every host byte is taken and every radio byte has arrived
  task automatic settle();
    while (host_q.size() != 0 || in_valid_i || radio_exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [ByteW-1:0] hdr;
    logic [ByteW-1:0] mask;
    logic [ByteW-1:0] cnt;
    logic [ByteW-1:0] nz;
    int               len;
    int               nfrm;
    int               phase;

    reg_copy = '0;
    reg_copy.channel_count = ChannelCountRst;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: bytes other than the header are dropped
    host_q.push_back(8'hFF);
    host_q.push_back(8'h5A);
    settle();

    // Every slot active, one byte per slot; radio side holds off meanwhile
    write_all(8'hA5, 8'hFF, 8'd1, 8'h00, 8'hF8);
    for (int i = int'(REG_CLOSE_CODE) + 1; i < (1 << IdxW); i++)
      write_reg(i[IdxW-1:0], 8'hFF);
    hold_req = 1'b1;
    host_q.push_back(8'h00);
    host_q.push_back(8'hA5);
    host_q.push_back(8'h00);
    host_q.push_back(8'hFF);
    host_q.push_back(8'hA5);  // header value inside a frame is data
    host_q.push_back(8'h01);
    host_q.push_back(8'h80);
    host_q.push_back(8'h7F);
    host_q.push_back(8'h55);
    host_q.push_back(8'hAA);
    settle();

    // Two bytes per slot, end slots active, mask changed in mid-slot
    write_all(8'hFF, 8'h81, 8'd2, 8'hFF, 8'h00);
    host_q.push_back(8'hFF);
    push_rand(3);
    settle();
    write_reg(REG_ACTIVE_MASK, 8'h7E);
    push_rand(13);
    settle();

    // Random frames with random settings
    phase = 0;
    while (phase < 4) begin
      calm = (phase % 3 == 2);
      hdr = 8'($urandom);
      mask = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom);
      cnt = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(7, 12)) : 8'($urandom_range(1, 4));
      write_all(hdr, mask, cnt, 8'($urandom), 8'($urandom));
      nfrm = $urandom_range(1, 2);
      for (int f = 0; f < nfrm; f++) begin
        repeat ($urandom_range(0, 2)) begin
          do nz = 8'($urandom); while (nz == hdr);
          host_q.push_back(nz);
        end
        host_q.push_back(hdr);
        len = 8 * int'(cnt);
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len - 1);  // cut-off frame
        if (phase % 4 == 3 && f == 0) begin
          push_rand(len / 2);
          settle();
          write_reg(REG_ACTIVE_MASK, 8'($urandom));
          push_rand(len - len / 2);
        end else begin
          push_rand(len);
        end
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    // Long slot: count 0 wraps to 256, then finish the frame one byte per slot
    write_all(8'h00, 8'h03, 8'd0, 8'h40, 8'hC0);
    host_q.push_back(8'h00);
    push_rand(256);
    settle();
    write_reg(REG_CHANNEL_COUNT, 8'd1);
    push_rand(7);
    settle();

    if (err_cnt == 0 && radio_exp_q.size() == 0) begin
      $display("receiver_frame_distributor verification clean");
    end else begin
      $display("receiver_frame_distributor verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rfd_pkg.sv
src/rfd_cfg_regs.sv
src/rfd_frame_ctrl.sv
src/rfd_out_buf.sv
src/receiver_frame_distributor.sv
dv/tb_receiver_frame_distributor.sv
